### rtl/upd_pkg.sv
// Package with the result type and character helpers of the URI percent decoder.
package upd_pkg;

  // One result transfer as held in the output buffer.
  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       string_end;
    logic       decode_error;
  } res_t;

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  localparam logic [7:0] PercentChar = 8'h25;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

  // Upper-case hex character for a nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] c;
    if (v < 4'd10) begin
      c = 8'h30 + {4'd0, v};
    end else begin
      c = 8'h37 + {4'd0, v};
    end
    return c;
  endfunction

  // Folds A-Z to a-z when enabled.
  function automatic logic [7:0] fold_char(input logic [7:0] c, input logic on);
    logic [7:0] r;
    r = c;
    if (on && c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  // True for zero and for the reserved characters that stay escaped.
  function automatic logic keep_encoded(input logic [7:0] c);
    logic k;
    unique case (c)
      8'h00, 8'h3A, 8'h2F, 8'h3F, 8'h23, 8'h5B, 8'h5D, 8'h40, 8'h21, 8'h24,
      8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D: k = 1'b1;
      default: k = 1'b0;
    endcase
    return k;
  endfunction

endpackage

### rtl/upd_in_if.sv
// Input channel of the URI percent decoder: one character per transfer.
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       string_last;
  logic       fold_lower;

  modport source (output valid, output in_byte, output string_last, output fold_lower,
                  input ready);
  modport sink (input valid, input in_byte, input string_last, input fold_lower,
                output ready);
endinterface

### rtl/upd_out_if.sv
// Output channel of the URI percent decoder: one result character per transfer.
interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       string_end;
  logic       decode_error;

  modport source (output valid, output out_byte, output run_end, output string_end,
                  output decode_error, input ready);
  modport sink (input valid, input out_byte, input run_end, input string_end,
                input decode_error, output ready);
endinterface

### rtl/uri_percent_decoder.sv
// Top level of the URI percent decoder.
//
// Characters of a URI component arrive on in_i, one per transfer, with
// string_last on the final one and fold_lower asking for A-Z to be folded.
// Decoded characters leave on out_o. A plain character gives one result, a
// kept escape gives three ('%' and two upper-case hex digits), the percent
// sign and first hex digit of an escape give none. A malformed escape drops
// the rest of the string and one error result closes it.
// A result is valid the cycle after its input transfer.
// One character per cycle while out_o accepts; a three-result escape holds
// in_i ready low while its results drain from the three-entry output
// buffer, one entry per cycle.
// A new character is taken while the last buffered result is being
// transferred, so a single-result stream runs without gaps.
// When the receiver stalls, results wait in the buffer and in_i.ready drops.
// Reset returns the decoder to plain text with an empty output buffer.
module uri_percent_decoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  upd_in_if.sink       in_i,
  upd_out_if.source    out_o
);

  localparam logic [1:0] PhText = 2'd0;
  localparam logic [1:0] PhPct  = 2'd1;
  localparam logic [1:0] PhHex1 = 2'd2;
  localparam logic [1:0] PhDrop = 2'd3;

  logic [1:0]        phase_q, phase_d;
  logic [3:0]        nibble_q, nibble_d;
  logic              lower_q, lower_d;
  logic [1:0]        cnt_q, cnt_d;
  upd_pkg::res_t     buf_q [3];
  upd_pkg::res_t     buf_d [3];
  upd_pkg::res_t     res   [3];
  logic [1:0]        n_res;
  logic              in_xfer, out_xfer;
  upd_pkg::hex_t     hex;
  logic [7:0]        dec_byte;
  upd_pkg::res_t     err_res;

  assign out_xfer    = out_o.valid && out_o.ready;
  assign in_i.ready  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_o.ready);
  assign in_xfer     = in_i.valid && in_i.ready;

  assign out_o.valid        = (cnt_q != 2'd0);
  assign out_o.out_byte     = buf_q[0].data;
  assign out_o.run_end      = buf_q[0].run_end;
  assign out_o.string_end   = buf_q[0].string_end;
  assign out_o.decode_error = buf_q[0].decode_error;

  assign hex      = upd_pkg::hex_decode(in_i.in_byte);
  assign dec_byte = {nibble_q, hex.value};
  assign err_res  = '{data: 8'd0, run_end: 1'b1, string_end: 1'b1, decode_error: 1'b1};

  // Decode one character against the escape phase.
  always_comb begin
    phase_d  = phase_q;
    nibble_d = nibble_q;
    lower_d  = lower_q;
    n_res    = 2'd0;
    for (int i = 0; i < 3; i++) begin
      res[i] = '{data: 8'd0, run_end: 1'b0, string_end: 1'b0, decode_error: 1'b0};
    end
    unique case (phase_q)
      PhText: begin
        if (in_i.in_byte == upd_pkg::PercentChar) begin
          if (in_i.string_last) begin
            res[0] = err_res;
            n_res  = 2'd1;
          end else begin
            lower_d = in_i.fold_lower;
            phase_d = PhPct;
          end
        end else begin
          res[0].data       = upd_pkg::fold_char(in_i.in_byte, in_i.fold_lower);
          res[0].run_end    = 1'b1;
          res[0].string_end = in_i.string_last;
          n_res             = 2'd1;
        end
      end
      PhPct: begin
        if (!hex.valid || in_i.string_last) begin
          if (in_i.string_last) begin
            res[0]  = err_res;
            n_res   = 2'd1;
            phase_d = PhText;
          end else begin
            phase_d = PhDrop;
          end
        end else begin
          nibble_d = hex.value;
          phase_d  = PhHex1;
        end
      end
      PhHex1: begin
        if (!hex.valid) begin
          if (in_i.string_last) begin
            res[0]  = err_res;
            n_res   = 2'd1;
            phase_d = PhText;
          end else begin
            phase_d = PhDrop;
          end
        end else begin
          phase_d = PhText;
          if (upd_pkg::keep_encoded(dec_byte)) begin
            res[0].data       = upd_pkg::PercentChar;
            res[1].data       = upd_pkg::hex_char(nibble_q);
            res[2].data       = upd_pkg::hex_char(hex.value);
            res[2].run_end    = 1'b1;
            res[2].string_end = in_i.string_last;
            n_res             = 2'd3;
          end else begin
            res[0].data       = upd_pkg::fold_char(dec_byte, lower_q);
            res[0].run_end    = 1'b1;
            res[0].string_end = in_i.string_last;
            n_res             = 2'd1;
          end
        end
      end
      default: begin
        if (in_i.string_last) begin
          res[0]  = err_res;
          n_res   = 2'd1;
          phase_d = PhText;
        end
      end
    endcase
  end

  // Output buffer: load on an input transfer, otherwise shift on an output transfer.
  always_comb begin
    cnt_d = cnt_q;
    for (int i = 0; i < 3; i++) begin
      buf_d[i] = buf_q[i];
    end
    if (in_xfer) begin
      cnt_d = n_res;
      for (int i = 0; i < 3; i++) begin
        buf_d[i] = res[i];
      end
    end else if (out_xfer) begin
      cnt_d    = cnt_q - 2'd1;
      buf_d[0] = buf_q[1];
      buf_d[1] = buf_q[2];
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhText;
      nibble_q <= 4'd0;
      lower_q  <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (in_xfer) begin
        phase_q  <= phase_d;
        nibble_q <= nibble_d;
        lower_q  <= lower_d;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      buf_q[i] <= buf_d[i];
    end
  end

endmodule
